### hw/rtl/fire_effect_frame_engine_core_defines.svh
// Assertion macros for the fire engine RTL (used by fe_back).
`ifndef FIRE_EFFECT_FRAME_ENGINE_CORE_DEFINES_SVH
`define FIRE_EFFECT_FRAME_ENGINE_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define FE_ASSERT(lbl, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("fe assertion failed");
`define FE_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fe assertion failed");
`else
`define FE_ASSERT(lbl, expr)
`define FE_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

### hw/rtl/fe_pkg.sv
`timescale 1ns / 1ps
package fe_pkg;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 9;
    localparam int HGT_CFG_W  = 8;

    localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd1;

    localparam logic [1:0] REQ_SEED    = 2'd0;
    localparam logic [1:0] REQ_ADVANCE = 2'd1;
    localparam logic [1:0] REQ_READ    = 2'd2;

    // work items after classification; OP_BLANK is a read outside the active area
    typedef enum logic [1:0] {
        OP_SEED,
        OP_ADVANCE,
        OP_READ,
        OP_BLANK
    } fe_op_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ADV,
        ST_ADV_WR,
        ST_READ_LOOK
    } fe_state_t;

    typedef struct packed {
        logic clearing;
    } fe_status_t;

    typedef logic [23:0] fe_rgb_t;
    typedef fe_rgb_t fe_palette_t [256];

    function automatic fe_rgb_t palette_entry(input int unsigned idx);
        int unsigned hue;
        int unsigned lit;
        int unsigned v;
        int unsigned m;
        int unsigned sext;
        int unsigned frac;
        int unsigned vsf;
        int unsigned up;
        int unsigned down;
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        hue = idx / 3;
        lit = (idx >= 127) ? 255 : idx * 2;
        if (lit < 128)
            v = (lit * 511) >> 8;
        else
            v = (((lit + 255) << 8) - lit * 255) >> 8;
        if (v == 0)
            return '0;
        m    = lit + lit - v;
        hue  = hue * 6;
        sext = hue >> 8;
        frac = hue - (sext << 8);
        // v*frac*(v-m)/v reduces exactly to frac*(v-m)
        vsf  = (frac * (v - m)) >> 8;
        up   = m + vsf;
        down = v - vsf;
        case (sext)
            0:       begin r = 8'(v);    g = 8'(up);   b = 8'(m);    end
            1:       begin r = 8'(down); g = 8'(v);    b = 8'(m);    end
            2:       begin r = 8'(m);    g = 8'(v);    b = 8'(up);   end
            3:       begin r = 8'(m);    g = 8'(down); b = 8'(v);    end
            4:       begin r = 8'(up);   g = 8'(m);    b = 8'(v);    end
            default: begin r = 8'(v);    g = 8'(m);    b = 8'(down); end
        endcase
        return {r, g, b};
    endfunction

    function automatic fe_palette_t build_palette();
        fe_palette_t p;
        for (int i = 0; i < 256; i++)
            p[i] = palette_entry(i);
        return p;
    endfunction

    localparam fe_palette_t PALETTE = build_palette();

endpackage

### hw/rtl/fe_ifs.sv
`timescale 1ns / 1ps
interface fe_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] req_type;
    logic [7:0] column;
    logic [6:0] screen_row;
    logic [7:0] seed_heat;

    modport source (output valid, req_type, column, screen_row, seed_heat, input ready);
    modport sink   (input valid, req_type, column, screen_row, seed_heat, output ready);
endinterface

interface fe_res_if;
    logic       valid;
    logic       ready;
    logic [7:0] heat;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;

    modport source (output valid, heat, red, green, blue, input ready);
    modport sink   (input valid, heat, red, green, blue, output ready);
endinterface

### hw/rtl/fe_queue.sv
`timescale 1ns / 1ps
module fe_queue #(
    parameter int DW = 8
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  logic [DW-1:0] push_data,
    input  logic          pop,
    output logic          full,
    output logic          valid,
    output logic [DW-1:0] head
);

    logic [DW-1:0] entry_reg [2];
    logic          wr_ptr_reg, wr_ptr_next;
    logic          rd_ptr_reg, rd_ptr_next;
    logic [1:0]    count_reg, count_next;

    assign full  = (count_reg == 2'd2);
    assign valid = (count_reg != 2'd0);
    assign head  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

### hw/rtl/fe_front.sv
`timescale 1ns / 1ps
module fe_front #(
    parameter int COLS_MAX = 256,
    parameter int ROWS_MAX = 128
) (
    input  logic                                         clk,
    input  logic                                         rst_n,
    fe_req_if.sink                                       req,
    input  logic                                         cfg_we,
    input  logic [fe_pkg::CFG_IDX_W-1:0]                 cfg_index,
    input  logic [fe_pkg::CFG_DATA_W-1:0]                cfg_data,
    input  fe_pkg::fe_status_t                           status,
    input  logic                                         q_full,
    output logic                                         q_push,
    output logic [2+$clog2(ROWS_MAX+1)+$clog2(COLS_MAX)+8-1:0] q_data,
    output logic [$clog2(COLS_MAX+1)-1:0]                width_in_use,
    output logic [$clog2(ROWS_MAX+1)-1:0]                height_in_use
);
    import fe_pkg::*;

    localparam int WID_W = $clog2(COLS_MAX + 1);
    localparam int HGT_W = $clog2(ROWS_MAX + 1);
    localparam int COL_W = $clog2(COLS_MAX);

    logic [WID_W-1:0] width_reg, width_next;
    logic [HGT_W-1:0] height_reg, height_next;
    logic [31:0]      cfg_val;
    logic             accept;
    logic             col_in;
    logic             row_in;
    fe_op_t           op;
    logic [HGT_W-1:0] row;

    assign width_in_use  = width_reg;
    assign height_in_use = height_reg;

    always_comb
    begin
        width_next  = width_reg;
        height_next = height_reg;
        cfg_val     = '0;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_WIDTH:
                begin
                    cfg_val = 32'(cfg_data);
                    if (cfg_val == 32'd0)
                        cfg_val = 32'd1;
                    if (cfg_val > 32'(COLS_MAX))
                        cfg_val = 32'(COLS_MAX);
                    width_next = WID_W'(cfg_val);
                end
                REG_HEIGHT:
                begin
                    cfg_val = 32'(cfg_data[HGT_CFG_W-1:0]);
                    if (cfg_val == 32'd0)
                        cfg_val = 32'd1;
                    if (cfg_val > 32'(ROWS_MAX))
                        cfg_val = 32'(ROWS_MAX);
                    height_next = HGT_W'(cfg_val);
                end
                default: ;
            endcase
        end
    end

    assign req.ready = !q_full && !status.clearing;
    assign accept    = req.valid && req.ready;
    assign col_in    = 32'(req.column) < 32'(width_reg);
    assign row_in    = 32'(req.screen_row) < 32'(height_reg);

    always_comb
    begin
        q_push = 1'b0;
        op     = OP_SEED;
        row    = '0;
        unique case (req.req_type)
            REQ_SEED:
            begin
                q_push = accept && col_in;
            end
            REQ_ADVANCE:
            begin
                q_push = accept;
                op     = OP_ADVANCE;
            end
            REQ_READ:
            begin
                q_push = accept;
                op     = (col_in && row_in) ? OP_READ : OP_BLANK;
                // screen row 0 shows the topmost fire row
                row    = HGT_W'(32'(height_reg) - 32'd1 - 32'(req.screen_row));
            end
            default: ;
        endcase
    end

    assign q_data = {op, row, COL_W'(req.column), req.seed_heat};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WID_W'(COLS_MAX);
            height_reg <= HGT_W'(ROWS_MAX);
        end
        else
        begin
            width_reg  <= width_next;
            height_reg <= height_next;
        end
    end

endmodule

### hw/rtl/fe_back.sv
`timescale 1ns / 1ps
`include "fire_effect_frame_engine_core_defines.svh"
module fe_back #(
    parameter int COLS_MAX = 256,
    parameter int ROWS_MAX = 128
) (
    input  logic                                         clk,
    input  logic                                         rst_n,
    input  logic                                         q_valid,
    input  logic [2+$clog2(ROWS_MAX+1)+$clog2(COLS_MAX)+8-1:0] q_head,
    output logic                                         q_pop,
    input  logic [$clog2(COLS_MAX+1)-1:0]                width_in_use,
    input  logic [$clog2(ROWS_MAX+1)-1:0]                height_in_use,
    output fe_pkg::fe_status_t                           status,
    fe_res_if.source                                     res
);
    import fe_pkg::*;

    localparam int WID_W  = $clog2(COLS_MAX + 1);
    localparam int HGT_W  = $clog2(ROWS_MAX + 1);
    localparam int COL_W  = $clog2(COLS_MAX);
    localparam int ADDR_W = HGT_W + COL_W;
    localparam int DEPTH  = (ROWS_MAX + 1) * (2 ** COL_W);
    localparam int ENT_W  = 2 + HGT_W + COL_W + 8;

    fe_state_t        state_reg, state_next;
    logic [ADDR_W-1:0] clr_addr_reg, clr_addr_next;
    logic [COL_W-1:0] x_reg, x_next;
    logic [HGT_W-1:0] y_reg, y_next;
    logic [2:0]       phase_reg, phase_next;
    logic [9:0]       sum_reg, sum_next;
    logic             out_valid_reg, out_valid_next;
    logic [7:0]       heat_reg, heat_next;
    fe_rgb_t          rgb_reg, rgb_next;
    logic [7:0]       rd_data_reg;

    logic [7:0]       mem [DEPTH];
    logic             mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [7:0]       mem_wdata;
    logic             mem_re;
    logic [ADDR_W-1:0] mem_raddr;

    fe_op_t           h_op;
    logic [HGT_W-1:0] h_row;
    logic [COL_W-1:0] h_col;
    logic [7:0]       h_data;
    logic             out_free;
    logic             clr_last;
    logic             last_col;
    logic             last_cell;
    logic [COL_W-1:0] left_col;
    logic [COL_W-1:0] right_col;
    logic [HGT_W-1:0] row2;
    logic [HGT_W-1:0] row3;
    logic [17:0]      prod;
    logic [7:0]       q0;
    logic [16:0]      rem;
    logic [7:0]       quot;

    assign h_op   = fe_op_t'(q_head[ENT_W-1 -: 2]);
    assign h_row  = q_head[COL_W+8 +: HGT_W];
    assign h_col  = q_head[8 +: COL_W];
    assign h_data = q_head[7:0];

    assign out_free  = !out_valid_reg || res.ready;
    assign clr_last  = 32'(clr_addr_reg) == 32'(DEPTH - 1);
    assign last_col  = (32'(x_reg) + 32'd1) == 32'(width_in_use);
    assign last_cell = last_col && (y_reg == HGT_W'(1));
    assign left_col  = (x_reg == '0) ? COL_W'(width_in_use - WID_W'(1)) : x_reg - COL_W'(1);
    assign right_col = last_col ? '0 : x_reg + COL_W'(1);
    assign row2      = (y_reg > HGT_W'(2)) ? y_reg - HGT_W'(2) : '0;
    assign row3      = (y_reg > HGT_W'(3)) ? y_reg - HGT_W'(3) : '0;

    // sum*64/257: q0 = sum*255 >> 10 is low by at most one
    assign prod = {sum_reg, 8'b0} - 18'(sum_reg);
    assign q0   = prod[17:10];
    assign rem  = 17'({sum_reg, 6'b0}) - (17'({q0, 8'b0}) + 17'(q0));
    assign quot = (rem >= 17'd257) ? q0 + 8'd1 : q0;

    assign status.clearing = (state_reg == ST_CLEAR);
    assign res.valid = out_valid_reg;
    assign res.heat  = heat_reg;
    assign res.red   = rgb_reg[23:16];
    assign res.green = rgb_reg[15:8];
    assign res.blue  = rgb_reg[7:0];

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
                if (clr_last)
                    state_next = ST_IDLE;
            ST_IDLE:
                if (q_valid)
                begin
                    unique case (h_op)
                        OP_ADVANCE: state_next = ST_ADV;
                        OP_READ:    state_next = ST_READ_LOOK;
                        OP_SEED:    state_next = ST_IDLE;
                        OP_BLANK:   state_next = ST_IDLE;
                    endcase
                end
            ST_ADV:
                if (phase_reg == 3'd4)
                    state_next = ST_ADV_WR;
            ST_ADV_WR:
                state_next = last_cell ? ST_IDLE : ST_ADV;
            ST_READ_LOOK:
                if (out_free)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        clr_addr_next  = clr_addr_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        phase_next     = phase_reg;
        sum_next       = sum_reg;
        out_valid_next = out_valid_reg && !res.ready;
        heat_next      = heat_reg;
        rgb_next       = rgb_reg;
        mem_we         = 1'b0;
        mem_waddr      = {h_row, h_col};
        mem_wdata      = h_data;
        mem_re         = 1'b0;
        mem_raddr      = {h_row, h_col};
        q_pop          = 1'b0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                mem_we        = 1'b1;
                mem_waddr     = clr_addr_reg;
                mem_wdata     = 8'd0;
                clr_addr_next = clr_addr_reg + ADDR_W'(1);
            end
            ST_IDLE:
                if (q_valid)
                begin
                    unique case (h_op)
                        OP_SEED:
                        begin
                            mem_we = 1'b1;
                            q_pop  = 1'b1;
                        end
                        OP_ADVANCE:
                        begin
                            q_pop      = 1'b1;
                            x_next     = '0;
                            y_next     = height_in_use;
                            phase_next = 3'd0;
                        end
                        OP_READ:
                        begin
                            mem_re = 1'b1;
                            q_pop  = 1'b1;
                        end
                        OP_BLANK:
                            if (out_free)
                            begin
                                q_pop          = 1'b1;
                                out_valid_next = 1'b1;
                                heat_next      = 8'd0;
                                rgb_next       = PALETTE[0];
                            end
                    endcase
                end
            ST_ADV:
            begin
                // phases 0-3 each issue one neighbor read; its data lands in rd_data_reg in the next phase
                unique case (phase_reg)
                    3'd0: mem_raddr = {y_reg - HGT_W'(1), left_col};
                    3'd1: mem_raddr = {y_reg - HGT_W'(1), right_col};
                    3'd2: mem_raddr = {row2, x_reg};
                    default: mem_raddr = {row3, x_reg};
                endcase
                mem_re     = (phase_reg != 3'd4);
                sum_next   = (phase_reg == 3'd0) ? 10'd0 : sum_reg + 10'(rd_data_reg);
                phase_next = (phase_reg == 3'd4) ? 3'd0 : phase_reg + 3'd1;
            end
            ST_ADV_WR:
            begin
                mem_we    = 1'b1;
                mem_waddr = {y_reg, x_reg};
                mem_wdata = quot;
                if (last_col)
                begin
                    x_next = '0;
                    y_next = y_reg - HGT_W'(1);
                end
                else
                    x_next = x_reg + COL_W'(1);
            end
            ST_READ_LOOK:
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    heat_next      = rd_data_reg;
                    rgb_next       = PALETTE[rd_data_reg];
                end
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        if (mem_re)
            rd_data_reg <= mem[mem_raddr];
    end

    always_ff @(posedge clk)
    begin
        x_reg     <= x_next;
        y_reg     <= y_next;
        sum_reg   <= sum_next;
        heat_reg  <= heat_next;
        rgb_reg   <= rgb_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_addr_reg  <= '0;
            phase_reg     <= 3'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_addr_reg  <= clr_addr_next;
            phase_reg     <= phase_next;
            out_valid_reg <= out_valid_next;
        end
    end

    `FE_ASSERT(a_clear_quiet, (state_reg == ST_CLEAR) |-> !out_valid_reg && !q_pop)
    `FE_ASSERT(a_pop_has_item, q_pop |-> q_valid)
    `FE_ASSERT(a_adv_row_nonzero, (state_reg == ST_ADV || state_reg == ST_ADV_WR) |-> y_reg != '0)
    `FE_ASSERT(a_sum_bound, (state_reg == ST_ADV_WR) |-> sum_reg <= 10'd1020)
    `FE_ASSERT_NEXT(a_read_look, (state_reg == ST_IDLE) && mem_re, state_reg == ST_READ_LOOK)

endmodule

### hw/rtl/fire_effect_frame_engine_core.sv
`timescale 1ns / 1ps
// channel | dir | handshake   | payload
// req     | in  | valid/ready | req_type, column, screen_row, seed_heat
// res     | out | valid/ready | heat, red, green, blue
// cfg     | in  | cfg_we      | cfg_index, cfg_data
//
// Seed: the back end writes the heat memory and pops. Read: memory read, then
// palette lookup. Advance: a pop, then per cell the ADV phases and ADV_WR over
// height_in_use*width_in_use cells; the single heat memory read port fetches the
// four neighbors. After reset a clearing pass zeroes all heat memory words,
// (ROWS_MAX+1)*2^ceil(log2 COLS_MAX) (33024 at default sizes); req.ready stays low
// meanwhile. A two-entry queue parts front from back; res stalls hold the back only.
module fire_effect_frame_engine_core #(
    parameter int COLS_MAX = 256,
    parameter int ROWS_MAX = 128
) (
    input  logic                         clk,
    input  logic                         rst_n,
    fe_req_if.sink                       req,
    fe_res_if.source                     res,
    input  logic                         cfg_we,
    input  logic [fe_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [fe_pkg::CFG_DATA_W-1:0] cfg_data
);
    import fe_pkg::*;

    localparam int WID_W = $clog2(COLS_MAX + 1);
    localparam int HGT_W = $clog2(ROWS_MAX + 1);
    localparam int ENT_W = 2 + HGT_W + $clog2(COLS_MAX) + 8;

    fe_status_t       status;
    logic             q_full;
    logic             q_push;
    logic             q_pop;
    logic             q_valid;
    logic [ENT_W-1:0] q_data;
    logic [ENT_W-1:0] q_head;
    logic [WID_W-1:0] width_in_use;
    logic [HGT_W-1:0] height_in_use;

    fe_front #(
        .COLS_MAX (COLS_MAX),
        .ROWS_MAX (ROWS_MAX)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .req           (req),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .status        (status),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_data        (q_data),
        .width_in_use  (width_in_use),
        .height_in_use (height_in_use)
    );

    fe_queue #(
        .DW (ENT_W)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_data),
        .pop       (q_pop),
        .full      (q_full),
        .valid     (q_valid),
        .head      (q_head)
    );

    fe_back #(
        .COLS_MAX (COLS_MAX),
        .ROWS_MAX (ROWS_MAX)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_valid       (q_valid),
        .q_head        (q_head),
        .q_pop         (q_pop),
        .width_in_use  (width_in_use),
        .height_in_use (height_in_use),
        .status        (status),
        .res           (res)
    );

endmodule
